/* hw/rtl/psvm_pkg.sv */
// Package for the polyphonic sample voice mixer.
// Holds sizes, function codes and the sequencer state type. No dependencies.
package psvm_pkg;
  localparam int VoiceCount = 16;
  localparam int VoiceW = $clog2(VoiceCount);
  localparam int CountW = 5;
  localparam int StoreDepth = 65536;
  localparam int StoreAw = $clog2(StoreDepth);

  typedef enum logic [1:0] {
    FuncLoad   = 2'd0,
    FuncNoteOn = 2'd1,
    FuncAllOff = 2'd2,
    FuncRender = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StIdle,
    StNote,
    StRdVoice,
    StRdSample,
    StMul,
    StAcc,
    StOut
  } state_e;

  typedef struct packed {
    logic [16:0] pos;
    logic [15:0] start;
    logic [16:0] len;
    logic [17:0] gain_l;
    logic [17:0] gain_r;
  } voice_t;
endpackage

/* hw/rtl/psvm_store.sv */
// Stereo sample store: one synchronous RAM, one write and one read port.
// Depends on psvm_pkg.
module psvm_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [psvm_pkg::StoreAw-1:0] waddr_i,
  input  logic [31:0]                 wdata_i,
  input  logic [psvm_pkg::StoreAw-1:0] raddr_i,
  output logic [31:0]                 rdata_o
);
  import psvm_pkg::*;
  logic [31:0] mem [StoreDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hw/rtl/polyphonic_sample_voice_mixer_unit.sv */
// Polyphonic sample voice mixer, top level.
// Load and all-off go straight to the output state; note-on passes a note state
// first. Render reads, multiplies and accumulates each voice, then outputs; one
// item in flight; the per-voice read, multiply and accumulate sets the pace.
// Result sits in an output register; a waiting result holds off the next request.
// Reset clears active flags and the sequencer; store and voice RAM are not cleared.
// Depends on psvm_pkg and psvm_store.
module polyphonic_sample_voice_mixer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] word_left_i,
  input  logic signed [15:0] word_right_i,
  input  logic [16:0]        length_i,
  input  logic [15:0]        velocity_i,
  input  logic [15:0]        level_i,
  input  logic signed [15:0] pan_i,
  input  logic signed [23:0] mix_left_in_i,
  input  logic signed [23:0] mix_right_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] left_out_o,
  output logic signed [23:0] right_out_o,
  output logic               accepted_o,
  output logic [4:0]         active_count_o
);
  import psvm_pkg::*;

  state_e state_q, state_d;
  logic [VoiceCount-1:0] act_q, act_d;
  logic [VoiceW-1:0] vidx_q, vidx_d;
  logic [15:0] addr_q;
  logic signed [15:0] pan_q;
  logic [16:0] len_q;
  logic signed [31:0] accl_q, accr_q, accl_d, accr_d;
  logic [16:0] vl_q;
  logic signed [34:0] prodl_q, prodr_q;
  logic [17:0] gl_q, gr_q;
  voice_t vmem [VoiceCount];
  voice_t vrd_q;
  logic vwe;
  logic [VoiceW-1:0] vaddr;
  voice_t vwd;
  logic [31:0] srd;
  logic [StoreAw-1:0] sraddr;
  logic live_q;
  logic out_busy;
  logic take;

  assign out_busy = out_valid_o && out_stall_i;
  assign in_stall_o = (state_q != StIdle) || out_busy;
  assign take = in_valid_i && !in_stall_o;

  psvm_store u_store (
    .clk_i  (clk_i),
    .we_i   (take && func_e'(func_i) == FuncLoad),
    .waddr_i(address_i),
    .wdata_i({word_left_i, word_right_i}),
    .raddr_i(sraddr),
    .rdata_o(srd)
  );
  assign sraddr = vrd_q.start + vrd_q.pos[15:0];

  // free voice search
  logic found;
  logic [VoiceW-1:0] free_idx;
  always_comb begin
    found = 1'b0;
    free_idx = '0;
    for (int i = VoiceCount - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        found = 1'b1;
        free_idx = VoiceW'(i);
      end
    end
  end

  logic [16:0] fl, fr;
  logic [32:0] gl_full, gr_full;
  always_comb begin
    fl = 17'd32768;
    fr = 17'd32768;
    if (pan_q < 0) fr = 17'(33'sd32768 + 33'(pan_q));
    else if (pan_q > 0) fl = 17'(33'sd32768 - 33'(pan_q));
    gl_full = 33'(vl_q) * 33'(fl);
    gr_full = 33'(vl_q) * 33'(fr);
  end

  function automatic logic signed [31:0] sat_in(logic signed [23:0] v);
    return 32'(v);
  endfunction

  function automatic logic [23:0] sat24(logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'h7FFFFF;
    if (v < -32'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // voice RAM
  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vaddr] <= vwd;
    vrd_q <= vmem[vaddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          unique case (func_e'(func_i))
            FuncNoteOn: state_d = StNote;
            FuncRender: state_d = StRdVoice;
            default:    state_d = StOut;
          endcase
        end
      end
      StNote:     state_d = StOut;
      StRdVoice:  state_d = StRdSample;
      StRdSample: state_d = StMul;
      StMul:      state_d = StAcc;
      StAcc:      state_d = (vidx_q == VoiceW'(VoiceCount - 1)) ? StOut : StRdVoice;
      StOut:      state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    act_d = act_q;
    vidx_d = vidx_q;
    accl_d = accl_q;
    accr_d = accr_q;
    vwe = 1'b0;
    vaddr = vidx_q;
    vwd = vrd_q;
    unique case (state_q)
      StIdle: begin
        vidx_d = '0;
        if (take) begin
          accl_d = sat_in(mix_left_in_i);
          accr_d = sat_in(mix_right_in_i);
          if (func_e'(func_i) == FuncAllOff) act_d = '0;
        end
      end
      StNote: begin
        if (len_q != 0 && found) begin
          vwe = 1'b1;
          vaddr = free_idx;
          vwd.pos = '0;
          vwd.start = addr_q;
          vwd.len = len_q;
          vwd.gain_l = gl_full[32:15];
          vwd.gain_r = gr_full[32:15];
          act_d[free_idx] = 1'b1;
        end
      end
      StRdSample: begin
        if (act_q[vidx_q]) begin
          if (vrd_q.pos >= vrd_q.len) begin
            act_d[vidx_q] = 1'b0;
          end else begin
            vwe = 1'b1;
            vwd.pos = vrd_q.pos + 17'd1;
          end
        end
      end
      StAcc: begin
        if (live_q) begin
          accl_d = accl_q + 32'(prodl_q >>> 7);
          accr_d = accr_q + 32'(prodr_q >>> 7);
        end
        vidx_d = vidx_q + VoiceW'(1);
      end
      default: ;
    endcase
  end

  logic [CountW-1:0] cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < VoiceCount; i++) cnt = cnt + CountW'(act_q[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      act_q <= '0;
      vidx_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      act_q <= act_d;
      vidx_q <= vidx_d;
      if (state_q == StOut) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    accl_q <= accl_d;
    accr_q <= accr_d;
    if (take) begin
      addr_q <= address_i;
      len_q <= length_i;
      vl_q <= 17'((32'(velocity_i) * 32'(level_i)) >> 15);
      pan_q <= pan_i;
      left_out_o <= '0;
      right_out_o <= '0;
      accepted_o <= 1'b0;
    end
    if (state_q == StNote) begin
      accepted_o <= (len_q != 0) && found;
    end
    if (state_q == StRdSample) begin
      live_q <= act_q[vidx_q] && (vrd_q.pos < vrd_q.len);
      gl_q <= vrd_q.gain_l;
      gr_q <= vrd_q.gain_r;
    end
    if (state_q == StMul) begin
      prodl_q <= 35'($signed(srd[31:16])) * $signed({17'd0, gl_q});
      prodr_q <= 35'($signed(srd[15:0])) * $signed({17'd0, gr_q});
    end
    if (state_q == StOut) begin
      active_count_o <= cnt;
    end
    if (state_q == StAcc && vidx_q == VoiceW'(VoiceCount - 1)) begin
      left_out_o <= sat24(accl_d);
      right_out_o <= sat24(accr_d);
    end
  end
endmodule
